// ===== hw/rtl/lcss_pkg.sv =====
// ----------------------------------------------------------------------------
// lcss_pkg
// shared types and codes for the lf clock switch sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lcss_pkg;

	localparam int DEFAULT_COUNT_WIDTH = 16;

	// source codes, same encoding on request and select
	localparam logic [2:0] SRC_RC       = 3'd0;
	localparam logic [2:0] SRC_XTAL     = 3'd1;
	localparam logic [2:0] SRC_SYNTH    = 3'd2;
	localparam logic [2:0] SRC_XTAL_LOW = 3'd3;
	localparam logic [2:0] SRC_XTAL_FULL = 3'd4;

	// word kinds
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic       op;
		logic [2:0] req_source;
		logic       lf_running;
		logic [1:0] running_source;
		logic       started_event;
		logic       lf_edge;
	} item_t;

	typedef struct packed {
		logic       stop_task;
		logic       start_task;
		logic       clear_started;
		logic [2:0] source_select;
		logic       busy_res;
		logic       done_res;
		logic       success;
	} result_t;

	typedef struct packed {
		logic        xtal_allowed;
		logic [15:0] stop_timeout_steps;
		logic [15:0] rc_start_timeout_steps;
		logic [15:0] ext_start_timeout_steps;
		logic [7:0]  edge_check_steps;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcss_in_stage.sv =====
// ----------------------------------------------------------------------------
// lcss_in_stage
// input register holding one accepted word for the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire lcss_pkg::item_t in_item,
	input  wire logic           advance,
	output logic                valid_s1,
	output lcss_pkg::item_t     item_s1
);
	import lcss_pkg::*;

	// free when empty or when the held word moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcss_seq_core.sv =====
// ----------------------------------------------------------------------------
// lcss_seq_core
// switch sequence state and next-state logic, one word per cycle while advance is high
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_seq_core #(
	parameter int COUNT_WIDTH = lcss_pkg::DEFAULT_COUNT_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire lcss_pkg::item_t  item,
	input  wire lcss_pkg::cfg_t   cfg,
	output lcss_pkg::result_t     res
);
	import lcss_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STOP,
		PH_START,
		PH_EDGE,
		PH_FB_STOP,
		PH_FB_START,
		PH_FB_EDGE
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n, cnt_bump;
	logic [2:0]             tgt_q, tgt_n;
	logic                   latch_q, latch_n;

	logic        fb, refused, is_xtal, seen;
	logic        do_stop, do_start, do_finish, ok, act_fb;
	logic [15:0] start_lim, win;

	function automatic logic [1:0] norm_src(input logic [2:0] s);
		logic [1:0] n;
		n = s[1:0];
		if (s == SRC_XTAL_LOW || s == SRC_XTAL_FULL) begin
			n = SRC_XTAL[1:0];
		end
		return n;
	endfunction

	// saturated counter counts as expired
	function automatic logic expired(input logic [COUNT_WIDTH-1:0] c, input logic [15:0] lim);
		return (CMP_W'(c) >= CMP_W'(lim)) || (&c);
	endfunction

	assign cnt_bump = (&cnt_q) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign fb = (phase_q == PH_FB_STOP) || (phase_q == PH_FB_START) || (phase_q == PH_FB_EDGE);
	assign is_xtal = (item.req_source == SRC_XTAL) || (item.req_source == SRC_XTAL_LOW)
		|| (item.req_source == SRC_XTAL_FULL);
	assign refused = (item.req_source > SRC_XTAL_FULL) || (is_xtal && !cfg.xtal_allowed);
	assign start_lim = (fb || tgt_q == SRC_RC) ? cfg.rc_start_timeout_steps
		: cfg.ext_start_timeout_steps;
	// zero window behaves as one step
	assign win = {8'h00, (cfg.edge_check_steps == 8'd0) ? 8'd1 : cfg.edge_check_steps};
	assign seen = latch_q || item.lf_edge;

	always_comb begin
		res       = '0;
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		tgt_n     = tgt_q;
		latch_n   = latch_q;
		do_stop   = 1'b0;
		do_start  = 1'b0;
		do_finish = 1'b0;
		ok        = 1'b0;
		act_fb    = 1'b0;

		case (phase_q)
			PH_IDLE: begin
				if (item.op == OP_REQUEST) begin
					if (refused) begin
						do_finish = 1'b1;
					end else if (item.lf_running
						&& item.running_source == norm_src(item.req_source)) begin
						do_finish = 1'b1;
						ok        = 1'b1;
					end else begin
						tgt_n   = item.req_source;
						do_stop = 1'b1;
					end
				end
			end
			PH_STOP, PH_FB_STOP: begin
				if (item.op == OP_TICK) begin
					if (!item.lf_running || expired(cnt_q, cfg.stop_timeout_steps)) begin
						do_start = 1'b1;
						act_fb   = fb;
					end else begin
						cnt_n = cnt_bump;
					end
				end
			end
			PH_START, PH_FB_START: begin
				if (item.op == OP_TICK) begin
					if (item.started_event) begin
						phase_n = fb ? PH_FB_EDGE : PH_EDGE;
						cnt_n   = '0;
						latch_n = 1'b0;
					end else if (expired(cnt_q, start_lim)) begin
						// a failed non-rc start falls back to rc
						if (fb || tgt_q == SRC_RC) begin
							do_finish = 1'b1;
						end else begin
							do_stop = 1'b1;
							act_fb  = 1'b1;
						end
					end else begin
						cnt_n = cnt_bump;
					end
				end
			end
			PH_EDGE, PH_FB_EDGE: begin
				if (item.op == OP_TICK) begin
					latch_n = seen;
					cnt_n   = cnt_bump;
					if (expired(cnt_bump, win)) begin
						latch_n = 1'b0;
						if (fb) begin
							do_finish = 1'b1;
						end else if (!seen) begin
							if (tgt_q == SRC_RC) begin
								do_finish = 1'b1;
							end else begin
								do_stop = 1'b1;
								act_fb  = 1'b1;
							end
						end else begin
							do_finish = 1'b1;
							ok = item.lf_running && item.running_source == norm_src(tgt_q);
						end
					end
				end
			end
			default: begin
				if (item.op == OP_TICK) begin
					phase_n = PH_IDLE;
				end
			end
		endcase

		// clock already stopped: go straight to the start
		if (do_stop && !item.lf_running) begin
			do_stop  = 1'b0;
			do_start = 1'b1;
		end

		if (do_stop) begin
			res.stop_task = 1'b1;
			phase_n       = act_fb ? PH_FB_STOP : PH_STOP;
			cnt_n         = '0;
		end
		if (do_start) begin
			res.start_task    = 1'b1;
			res.clear_started = 1'b1;
			res.source_select = act_fb ? SRC_RC : tgt_n;
			phase_n           = act_fb ? PH_FB_START : PH_START;
			cnt_n             = '0;
		end
		if (do_finish) begin
			res.done_res = 1'b1;
			res.success  = ok;
			phase_n      = PH_IDLE;
			cnt_n        = '0;
		end
		res.busy_res = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			tgt_q   <= SRC_RC;
			latch_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			tgt_q   <= tgt_n;
			latch_q <= latch_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcss_out_stage.sv =====
// ----------------------------------------------------------------------------
// lcss_out_stage
// result register toward the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire lcss_pkg::result_t res,
	output logic                   ready,
	output logic                   valid_s2,
	output lcss_pkg::result_t      res_s2,
	input  wire logic              out_ready
);
	import lcss_pkg::*;

	assign ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lf_clock_switch_sequencer.sv =====
// ----------------------------------------------------------------------------
// lf_clock_switch_sequencer
// low-frequency clock source switch sequencer with rc failover
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one word per switch request (s_tuser = 1) or poll tick
//   (s_tuser = 0); tdata carries the requested source and oscillator status
//   m_* stream: exactly one result word per input word, in order, carrying
//   the stop/start/clear pulses, the source to program and busy/done/success
//   apb port: five config registers at byte addresses 0, 4, 8, 12, 16;
//   write only while no word is in flight
// timing
//   one word per cycle sustained; a word accepted at edge k shows on m_* after
//   edge k+1 (input register, then next-state logic into the result register)
//   the sequence state updates once per word as it leaves the input register
// reset
//   arst_n clears both stages, the phase (idle), the wait counter, the target
//   source (rc) and the edge latch; config returns to its defaults
// stall
//   while m_tready is low the result holds, one more word waits in the input
//   register, then s_tready drops; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module lf_clock_switch_sequencer #(
	parameter int COUNT_WIDTH = lcss_pkg::DEFAULT_COUNT_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// req_source[2:0], lf_running[3], running_source[5:4], started_event[6],
	// lf_edge[7]
	input  wire logic [7:0]  s_tdata,
	// op[0]
	input  wire logic        s_tuser,
	// result words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// stop_task[0], start_task[1], clear_started[2], source_select[5:3],
	// busy_res[6], done_res[7], success[8], zero fill [15:9]
	output logic [15:0]      m_tdata,
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lcss_pkg::*;

	// register map, word index
	localparam logic [2:0] REG_XTAL_ALLOWED = 3'd0;
	localparam logic [2:0] REG_STOP_TO      = 3'd1;
	localparam logic [2:0] REG_RC_START_TO  = 3'd2;
	localparam logic [2:0] REG_EXT_START_TO = 3'd3;
	localparam logic [2:0] REG_EDGE_STEPS   = 3'd4;

	cfg_t    cfg_q;
	item_t   in_item, item_s1;
	result_t res, res_s2;
	logic    valid_s1, valid_s2, ready_s2, advance;
	logic    cfg_wr;
	logic [2:0] reg_idx;

	// ------------------------------------------------------------------
	// config registers
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.xtal_allowed            <= 1'b1;
			cfg_q.stop_timeout_steps      <= 16'd2000;
			cfg_q.rc_start_timeout_steps  <= 16'd2000;
			cfg_q.ext_start_timeout_steps <= 16'd20000;
			cfg_q.edge_check_steps        <= 8'd6;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_XTAL_ALLOWED: cfg_q.xtal_allowed            <= pwdata[0];
				REG_STOP_TO:      cfg_q.stop_timeout_steps      <= pwdata[15:0];
				REG_RC_START_TO:  cfg_q.rc_start_timeout_steps  <= pwdata[15:0];
				REG_EXT_START_TO: cfg_q.ext_start_timeout_steps <= pwdata[15:0];
				REG_EDGE_STEPS:   cfg_q.edge_check_steps        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back, unmapped addresses read zero
	always_comb begin
		case (reg_idx)
			REG_XTAL_ALLOWED: prdata = {31'd0, cfg_q.xtal_allowed};
			REG_STOP_TO:      prdata = {16'd0, cfg_q.stop_timeout_steps};
			REG_RC_START_TO:  prdata = {16'd0, cfg_q.rc_start_timeout_steps};
			REG_EXT_START_TO: prdata = {16'd0, cfg_q.ext_start_timeout_steps};
			REG_EDGE_STEPS:   prdata = {24'd0, cfg_q.edge_check_steps};
			default:          prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// input unpacking
	// ------------------------------------------------------------------
	assign in_item.op             = s_tuser;
	assign in_item.req_source     = s_tdata[2:0];
	assign in_item.lf_running     = s_tdata[3];
	assign in_item.running_source = s_tdata[5:4];
	assign in_item.started_event  = s_tdata[6];
	assign in_item.lf_edge        = s_tdata[7];

	// word moves from input register to result register
	assign advance = valid_s1 && ready_s2;

	lcss_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// sequence state machine, updates only on advance
	lcss_seq_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	lcss_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res       (res),
		.ready     (ready_s2),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2),
		.out_ready (m_tready)
	);

	// ------------------------------------------------------------------
	// output packing
	// ------------------------------------------------------------------
	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.success, res_s2.done_res, res_s2.busy_res,
		res_s2.source_select, res_s2.clear_started, res_s2.start_task,
		res_s2.stop_task};

endmodule

`default_nettype wire

// ===== hw/rtl/lcss_checker.sv =====
// ----------------------------------------------------------------------------
// lcss_checker
// port-level checks on the result stream of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module lcss_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	localparam int B_STOP  = 0;
	localparam int B_START = 1;
	localparam int B_CLR   = 2;
	localparam int B_BUSY  = 6;
	localparam int B_DONE  = 7;
	localparam int B_OK    = 8;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a finished sequence leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[B_DONE] |-> !m_tdata[B_BUSY])
		else $error("done together with busy");

	// start always clears the flag, select only with start, success only with done
	a_start_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[B_START] == m_tdata[B_CLR])
			&& (m_tdata[B_START] || m_tdata[5:3] == 3'd0)
			&& (m_tdata[B_DONE] || !m_tdata[B_OK]))
		else $error("inconsistent start or success fields");

	// one action per word
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[B_STOP] && m_tdata[B_START])
			&& !(m_tdata[B_DONE] && (m_tdata[B_STOP] || m_tdata[B_START])))
		else $error("more than one action in a result");

endmodule

bind lf_clock_switch_sequencer lcss_checker u_lcss_checker (.*);

`default_nettype wire
